[hdl/assert_macros.svh]
// assertion macros shared by the focus index detector modules
// each macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every sampled edge
`define OFID_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define OFID_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ofid_pkg.sv]
// package for the focus index detector: widths, byte codes, prefix table,
// result struct shared between the value tracker and the output stage
// no dependencies
package ofid_pkg;

    localparam int DEFAULT_INDEX_BITS = 16;
    localparam int COUNT_W            = 16;
    localparam int HL_W               = 16;
    localparam int BYTE_W             = 8;
    localparam int PREFIX_LEN         = 12;
    localparam int PREFIX_CNT_W       = $clog2(PREFIX_LEN);
    localparam int IN_TDATA_W         = 8;
    localparam int OUT_TDATA_W        = 24;

    localparam logic [BYTE_W-1:0] BEL_BYTE = 8'h07;
    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h1B;
    localparam logic [BYTE_W-1:0] DIGIT_0  = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_9  = 8'h39;

    typedef struct packed {
        logic            valid;
        logic            accepted;
        logic            present;
        logic [HL_W-1:0] index;
    } ofid_result_t;

    // expected byte at each prefix position: ESC ] 6 9 7 ; f o c u s ;
    function automatic logic [BYTE_W-1:0] prefix_byte(input logic [PREFIX_CNT_W-1:0] pos);
        logic [BYTE_W-1:0] b;
        unique case (pos)
            4'd0:    b = ESC_BYTE;
            4'd1:    b = 8'h5D;
            4'd2:    b = 8'h36;
            4'd3:    b = 8'h39;
            4'd4:    b = 8'h37;
            4'd5:    b = 8'h3B;
            4'd6:    b = 8'h66;
            4'd7:    b = 8'h6F;
            4'd8:    b = 8'h63;
            4'd9:    b = 8'h75;
            4'd10:   b = 8'h73;
            4'd11:   b = 8'h3B;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[hdl/ofid_scan.sv]
// prefix scanner: tracks how many bytes of the escape prefix have matched
// depends on ofid_pkg
module ofid_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_accept,
    input  logic [ofid_pkg::BYTE_W-1:0] data_byte,
    input  logic                       in_value,
    output logic                       prefix_done
);
    import ofid_pkg::*;

    logic [PREFIX_CNT_W-1:0] match_cnt_reg;
    logic [PREFIX_CNT_W-1:0] match_cnt_next;
    logic                    last_pos;
    logic                    hit;

    assign last_pos = (match_cnt_reg == PREFIX_CNT_W'(PREFIX_LEN - 1));
    assign hit      = (data_byte == prefix_byte(match_cnt_reg));

    always_comb
    begin
        match_cnt_next = match_cnt_reg;
        prefix_done    = 1'b0;
        if (byte_accept && !in_value)
        begin
            if (hit)
            begin
                if (last_pos)
                begin
                    match_cnt_next = '0;
                    prefix_done    = 1'b1;
                end
                else
                begin
                    match_cnt_next = match_cnt_reg + PREFIX_CNT_W'(1);
                end
            end
            else
            begin
                // a mismatching ESC still opens a new attempt
                match_cnt_next = (data_byte == ESC_BYTE) ? PREFIX_CNT_W'(1) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_cnt_reg <= '0;
        else
            match_cnt_reg <= match_cnt_next;
    end

endmodule

[hdl/ofid_value.sv]
// value collector and highlight state: accumulates decimal digits after the
// prefix, checks the value on BEL and updates the highlighted index
// depends on ofid_pkg
module ofid_value #(
    parameter int INDEX_BITS = ofid_pkg::DEFAULT_INDEX_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ofid_pkg::COUNT_W-1:0] cfg_wdata,
    input  logic                         byte_accept,
    input  logic [ofid_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         prefix_done,
    output logic                         in_value,
    output ofid_pkg::ofid_result_t       result
);
    import ofid_pkg::*;

    localparam int PROD_W = INDEX_BITS + 4;
    localparam int CMP_W  = (INDEX_BITS > COUNT_W) ? INDEX_BITS : COUNT_W;

    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic                  in_value_reg;
    logic                  in_value_next;
    logic [INDEX_BITS-1:0] accum_reg;
    logic [INDEX_BITS-1:0] accum_next;
    logic                  too_large_reg;
    logic                  too_large_next;
    logic                  has_digit_reg;
    logic                  has_digit_next;
    logic                  bad_char_reg;
    logic                  bad_char_next;
    logic                  hl_valid_reg;
    logic                  hl_valid_next;
    logic [HL_W-1:0]       hl_reg;
    logic [HL_W-1:0]       hl_next;

    logic                  is_bel;
    logic                  is_digit;
    logic [PROD_W-1:0]     prod;
    logic                  overflow;
    logic                  in_range;
    logic                  ok;

    assign is_bel   = (data_byte == BEL_BYTE);
    assign is_digit = (data_byte >= DIGIT_0) && (data_byte <= DIGIT_9);
    // accum * 10 + digit as two shifts and two adds
    assign prod     = PROD_W'({accum_reg, 3'b000}) + PROD_W'({accum_reg, 1'b0})
                    + PROD_W'(4'(data_byte - DIGIT_0));
    assign overflow = |prod[PROD_W-1:INDEX_BITS];
    assign in_range = (CMP_W'(accum_reg) < CMP_W'(count_reg));
    assign ok       = has_digit_reg && !bad_char_reg && !too_large_reg && in_range;

    always_comb
    begin
        count_next     = count_reg;
        in_value_next  = in_value_reg;
        accum_next     = accum_reg;
        too_large_next = too_large_reg;
        has_digit_next = has_digit_reg;
        bad_char_next  = bad_char_reg;
        hl_valid_next  = hl_valid_reg;
        hl_next        = hl_reg;
        result         = '0;

        if (cfg_we)
        begin
            count_next    = cfg_wdata;
            hl_valid_next = (cfg_wdata != '0);
            hl_next       = '0;
        end
        else if (byte_accept)
        begin
            if (in_value_reg)
            begin
                priority if (is_bel)
                begin
                    in_value_next = 1'b0;
                    if (ok)
                    begin
                        hl_valid_next = 1'b1;
                        hl_next       = HL_W'(accum_reg);
                    end
                    result.valid    = 1'b1;
                    result.accepted = ok;
                    result.present  = hl_valid_next;
                    result.index    = hl_valid_next ? hl_next : '0;
                end
                else if (is_digit)
                begin
                    has_digit_next = 1'b1;
                    if (!too_large_reg)
                    begin
                        // sticky: accumulation freezes once the value overflows
                        if (overflow)
                            too_large_next = 1'b1;
                        else
                            accum_next = prod[INDEX_BITS-1:0];
                    end
                end
                else
                begin
                    bad_char_next = 1'b1;
                end
            end
            else if (prefix_done)
            begin
                in_value_next  = 1'b1;
                accum_next     = '0;
                too_large_next = 1'b0;
                has_digit_next = 1'b0;
                bad_char_next  = 1'b0;
            end
        end
    end

    assign in_value = in_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            in_value_reg  <= 1'b0;
            accum_reg     <= '0;
            too_large_reg <= 1'b0;
            has_digit_reg <= 1'b0;
            bad_char_reg  <= 1'b0;
            hl_valid_reg  <= 1'b0;
            hl_reg        <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            in_value_reg  <= in_value_next;
            accum_reg     <= accum_next;
            too_large_reg <= too_large_next;
            has_digit_reg <= has_digit_next;
            bad_char_reg  <= bad_char_next;
            hl_valid_reg  <= hl_valid_next;
            hl_reg        <= hl_next;
        end
    end

`include "assert_macros.svh"

    `OFID_ASSERT(a_hl_needs_count, !hl_valid_reg || (count_reg != '0), "highlight without candidates")
    `OFID_ASSERT(a_hl_zero_when_absent, hl_valid_reg || (hl_reg == '0), "stale highlight index")

endmodule

[hdl/ofid_out_reg.sv]
// output stage: result register plus one skid entry so a new byte can be
// taken while a result waits; packs the result fields into m_tdata
// depends on ofid_pkg
module ofid_out_reg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ofid_pkg::ofid_result_t           result,
    output logic                             in_ready,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ofid_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ofid_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - HL_W - 2;

    ofid_result_t main_reg;
    ofid_result_t main_next;
    ofid_result_t skid_reg;
    ofid_result_t skid_next;
    logic         main_valid_reg;
    logic         main_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (m_tready || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = result;
                main_valid_next = result.valid;
            end
        end
        else if (result.valid)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {PAD_W'(0), main_reg.index, main_reg.present, main_reg.accepted};

`include "assert_macros.svh"

    `OFID_ASSERT(a_skid_behind_main, !skid_valid_reg || main_valid_reg, "skid full while main empty")
    `OFID_ASSERT_NEXT(a_skid_drains, skid_valid_reg && m_tready, !skid_valid_reg, "skid not drained")

endmodule

[hdl/osc_focus_index_detector.sv]
// top level of the focus index detector: byte stream in, one result per
// terminated notification out
// depends on ofid_pkg, ofid_scan, ofid_value, ofid_out_reg
//
// usage:
//   s_tvalid/s_tready/s_tdata carry the byte stream, one byte per request.
//   m_tvalid/m_tready/m_tdata carry one result for each BEL that closes a
//   value after the ESC ] 697;focus; prefix; other bytes give no result.
//   cfg_we/cfg_wdata write candidate_count; the highlight then becomes index 0
//   when the count is nonzero, absent otherwise. write only while idle.
//   throughput: one byte per cycle while s_tready is high; the match, digit accumulate and range
//   check are combinational between the scanner state and the result register.
//   result path: the result of a taken BEL is registered in the output register or skid entry.
//   stall: a result waiting on m_tready sits in the output register while
//   input continues; a second result goes to a skid entry and s_tready drops
//   until the receiver takes the first one.
//   reset: scanner idle, candidate_count 0, no highlight, output empty.
module osc_focus_index_detector #(
    parameter int INDEX_BITS = ofid_pkg::DEFAULT_INDEX_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ofid_pkg::COUNT_W-1:0]     cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ofid_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ofid_pkg::OUT_TDATA_W-1:0] m_tdata    // [0] accepted,
                                                         // [1] highlight_present,
                                                         // [17:2] highlight index,
                                                         // [23:18] zero
);
    import ofid_pkg::*;

    logic         byte_accept;
    logic         prefix_done;
    logic         in_value;
    ofid_result_t result;

    assign byte_accept = s_tvalid && s_tready;

    ofid_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .data_byte   (s_tdata[BYTE_W-1:0]),
        .in_value    (in_value),
        .prefix_done (prefix_done)
    );

    ofid_value #(
        .INDEX_BITS (INDEX_BITS)
    ) u_value (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .byte_accept (byte_accept),
        .data_byte   (s_tdata[BYTE_W-1:0]),
        .prefix_done (prefix_done),
        .in_value    (in_value),
        .result      (result)
    );

    ofid_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`include "assert_macros.svh"

    `OFID_ASSERT(a_accept_implies_present, !m_tvalid || !m_tdata[0] || m_tdata[1], "accepted without highlight")
    `OFID_ASSERT(a_absent_index_zero, !m_tvalid || m_tdata[1] || (m_tdata[17:2] == '0), "index set without highlight")

endmodule

[test/ofid_checker.sv]
// checker for the focus index detector: watches the config port and both
// stream channels, predicts each notification result and compares it
// depends on ofid_pkg
`timescale 1ns / 1ps

module ofid_checker #(
    parameter int INDEX_BITS = ofid_pkg::DEFAULT_INDEX_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ofid_pkg::COUNT_W-1:0]     cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [ofid_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [ofid_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                               fail_count,
    output int                               pending,
    output int                               results_seen,
    output int                               taken_seen
);
    import ofid_pkg::*;

    localparam logic [8*PREFIX_LEN-1:0] FOCUS_PREFIX = {ESC_BYTE, "]697;focus;"};
    localparam longint unsigned INDEX_MAX = (64'd1 << INDEX_BITS) - 1;

    typedef struct packed {
        logic            accepted;
        logic            present;
        logic [HL_W-1:0] index;
    } focus_note_t;

    focus_note_t notes_q[$];

    // predicted block state
    logic [COUNT_W-1:0] cand_count;
    int                 match_pos;
    logic               collecting;
    longint unsigned    accum;
    logic               too_large;
    logic               has_digit;
    logic               bad_char;
    logic               hl_valid;
    logic [HL_W-1:0]    hl_index;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
        fail_count++;
    endtask

    task automatic scan_byte(input logic [BYTE_W-1:0] b);
        focus_note_t     note;
        logic            ok;
        longint unsigned nxt;
        if (collecting)
        begin
            if (b == BEL_BYTE)
            begin
                ok = has_digit && !bad_char && !too_large && accum < cand_count;
                if (ok)
                begin
                    hl_valid = 1'b1;
                    hl_index = accum[HL_W-1:0];
                end
                collecting    = 1'b0;
                match_pos     = 0;
                note.accepted = ok;
                note.present  = hl_valid;
                note.index    = hl_valid ? hl_index : '0;
                notes_q       = {notes_q, note};
            end
            else if (b >= DIGIT_0 && b <= DIGIT_9)
            begin
                has_digit = 1'b1;
                if (!too_large)
                begin
                    nxt = accum * 10 + (b - DIGIT_0);
                    if (nxt > INDEX_MAX)
                        too_large = 1'b1;
                    else
                        accum = nxt;
                end
            end
            else
            begin
                bad_char = 1'b1;
            end
        end
        else if (b == FOCUS_PREFIX[8*(PREFIX_LEN-1-match_pos) +: 8])
        begin
            match_pos++;
            if (match_pos == PREFIX_LEN)
            begin
                match_pos  = 0;
                collecting = 1'b1;
                accum      = 0;
                too_large  = 1'b0;
                has_digit  = 1'b0;
                bad_char   = 1'b0;
            end
        end
        else
        begin
            // a mismatching ESC already starts the next prefix
            match_pos = (b == ESC_BYTE) ? 1 : 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        focus_note_t want;
        if (!rst_n)
        begin
            notes_q.delete();
            cand_count   = '0;
            match_pos    = 0;
            collecting   = 1'b0;
            accum        = 0;
            too_large    = 1'b0;
            has_digit    = 1'b0;
            bad_char     = 1'b0;
            hl_valid     = 1'b0;
            hl_index     = '0;
            fail_count   = 0;
            pending      = 0;
            results_seen = 0;
            taken_seen   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (m_tdata[0])
                    taken_seen++;
                if (notes_q.size() == 0)
                begin
                    report_mismatch("result with nothing expected", m_tdata, 0);
                end
                else
                begin
                    want = notes_q.pop_front();
                    if (m_tdata[0] !== want.accepted)
                        report_mismatch("accepted", m_tdata[0], want.accepted);
                    if (m_tdata[1] !== want.present)
                        report_mismatch("highlight_present", m_tdata[1], want.present);
                    if (m_tdata[17:2] !== want.index)
                        report_mismatch("highlight index", m_tdata[17:2], want.index);
                    if (m_tdata[OUT_TDATA_W-1:18] !== '0)
                        report_mismatch("padding bits", m_tdata[OUT_TDATA_W-1:18], 0);
                end
            end
            if (cfg_we)
            begin
                cand_count = cfg_wdata;
                hl_valid   = (cfg_wdata != '0);
                hl_index   = '0;
            end
            if (s_tvalid && s_tready)
                scan_byte(s_tdata);
            pending = notes_q.size();
        end
    end

endmodule

[test/osc_focus_index_detector_tb.sv]
// testbench top for osc_focus_index_detector: drives the byte stream, the
// candidate count register and the result back-pressure; ofid_checker predicts
// and compares. depends on ofid_pkg, ofid_checker and the detector rtl
`timescale 1ns / 1ps

module osc_focus_index_detector_tb;

    import ofid_pkg::*;

    localparam logic [8*PREFIX_LEN-1:0] FOCUS_PREFIX = {ESC_BYTE, "]697;focus;"};
    localparam int RANDOM_SEGMENTS  = 8;
    localparam int SEGMENT_BYTES    = 120;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES     = 8;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [COUNT_W-1:0]     cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;     // [7:0] data_byte
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;     // [0] accepted, [1] highlight_present,
                                         // [17:2] highlight index, [23:18] zero

    int fail_count;
    int pending;
    int results_seen;
    int taken_seen;

    int          bytes_sent   = 0;
    int          cfg_writes   = 0;
    int unsigned cur_count    = 0;
    logic        tx_steady    = 1'b0;
    logic        rx_steady    = 1'b0;
    logic        hold_req     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    osc_focus_index_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ofid_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .taken_seen   (taken_seen)
    );

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stalls, steady stretches and one long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (rx_steady)
            begin
                m_tready = 1'b1;
            end
            else
            begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 70)
                    m_tready = 1'b1;
                else if (r < 95)
                    m_tready = 1'b0;
                else
                begin
                    m_tready = 1'b0;
                    repeat ($urandom_range(10, 40)) @(negedge clk);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // valid stays high after the request until the next call's falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_prefix(input int len);
        for (int i = 0; i < len; i++)
            send_byte(FOCUS_PREFIX[8*(PREFIX_LEN-1-i) +: 8]);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_note(input string value);
        send_prefix(PREFIX_LEN);
        send_text(value);
        send_byte(BEL_BYTE);
    endtask

    // only while idle: input quiet and every result drained
    task automatic write_candidate_count(input int unsigned n);
        @(negedge clk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = n[COUNT_W-1:0];
        cur_count = n;
        cfg_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_random_note();
        int          kind;
        int unsigned v;
        string       digits;
        logic [7:0]  junk;
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
        begin
            send_prefix($urandom_range(1, PREFIX_LEN - 1));
            send_byte(8'($urandom_range(0, 255)));
        end
        send_prefix(PREFIX_LEN);
        kind = $urandom_range(0, 99);
        if (kind < 50)
        begin
            v = (cur_count > 0) ? $urandom_range(0, cur_count - 1) : $urandom_range(0, 9);
            digits = ($urandom_range(0, 3) == 0) ? "00" : "";
            send_text({digits, $sformatf("%0d", v)});
        end
        else if (kind < 65)
        begin
            send_text($sformatf("%0d", $urandom_range(cur_count, 65535)));
        end
        else if (kind < 75)
        begin
            send_text($sformatf("%0d", $urandom_range(65536, 99999999)));
        end
        else if (kind < 83)
        begin
            // empty value
        end
        else if (kind < 93)
        begin
            digits = $sformatf("%0d", $urandom_range(0, 65535));
            do
                junk = 8'($urandom_range(0, 255));
            while ((junk >= DIGIT_0 && junk <= DIGIT_9) || junk == BEL_BYTE);
            send_text(digits.substr(0, 0));
            send_byte(junk);
            send_text(digits.substr(1, digits.len() - 1));
        end
        else
        begin
            // a fresh prefix inside the value spoils it
            send_text("1");
            send_prefix(PREFIX_LEN);
            send_text("2");
        end
        send_byte(BEL_BYTE);
    endtask

    initial
    begin
        int seg_end;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // count still at its reset value: no highlight, nothing accepted
        send_note("0");

        write_candidate_count(10);
        send_note("3");
        send_note("");
        send_note("0007");
        send_note("10");
        send_note("3a");
        send_text("x");
        send_prefix(PREFIX_LEN);
        send_text("1");
        send_note("2");
        send_prefix(3);
        send_note("5");
        send_prefix(7);
        send_byte("x");
        send_note("2");
        send_byte(BEL_BYTE);
        send_note("99999");
        send_note("9");

        write_candidate_count(65535);
        send_note("65535");
        send_note("65534");
        send_note("000000065534");
        send_note("65536");
        send_note("6553500");

        write_candidate_count(0);
        send_note("0");
        write_candidate_count(1);
        send_note("0");

        // several results while the receiver holds off: the block must stall input
        write_candidate_count(20);
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        for (int i = 0; i < 6; i++)
            send_note($sformatf("%0d", i * 3));
        tx_steady = 1'b0;

        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++)
        begin
            case (seg)
                0: write_candidate_count($urandom_range(2, 20));
                1: write_candidate_count(65535);
                2: write_candidate_count(0);
                3: write_candidate_count(1);
                4: write_candidate_count($urandom_range(0, 65535));
                5: write_candidate_count($urandom_range(100, 1000));
                6: write_candidate_count(3);
                default: write_candidate_count($urandom_range(0, 65535));
            endcase
            tx_steady = (seg % 3 == 1);
            rx_steady = (seg % 4 == 2);
            seg_end = bytes_sent + SEGMENT_BYTES;
            while (bytes_sent < seg_end)
                send_random_note();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        @(negedge clk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d stream bytes across %0d candidate count settings",
                 bytes_sent, cfg_writes);
        $display("checked %0d notifications, %0d of them took a new highlight",
                 results_seen, taken_seen);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
